// File: design/vcsc_pkg.sv
package vcsc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TAN_WIDTH   = 23;

    localparam logic [TAN_WIDTH-1:0] TAN_RESET = TAN_WIDTH'(1 << FRAC_BITS);

    // endpoints plus status carried between the two cone-line clippers
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [COORD_WIDTH-1:0] x1;
        logic signed [COORD_WIDTH-1:0] y1;
        logic                          rej;
        logic                          ovf;
    } seg_t;

endpackage

// File: design/view_cone_segment_clipper_unit.sv
// Throughput: one request per cycle while the output is not stalled; each cone
//   line has its own pipelined divider that retires one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n, async, active low) empties the pipeline and sets the view
//   tangent to 1.0.
module view_cone_segment_clipper_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // tangent write port
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vcsc_pkg::TAN_WIDTH-1:0]         cfg_data,
    // segment request
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] start_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] start_y,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] end_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] end_y,
    // clipped result
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_start_x,
    output logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_start_y,
    output logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_end_x,
    output logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_end_y,
    output logic                                   rejected,
    output logic                                   overflow
);

    localparam int CW = vcsc_pkg::COORD_WIDTH;

    // -1.0 in fixed point, shown on every coordinate of a rejected segment
    localparam logic signed [CW-1:0] MINUS_ONE = -$signed(CW'(1 << vcsc_pkg::FRAC_BITS));

    logic [vcsc_pkg::TAN_WIDTH-1:0] tan_reg;
    logic                           en;
    vcsc_pkg::seg_t                 seg_in, seg_mid, seg_out;
    logic                           v_mid;

    // tangent register; the user must write it only while the pipe is idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tan_reg <= vcsc_pkg::TAN_RESET;
        end
        else if (cfg_valid)
        begin
            tan_reg <= cfg_data;
        end
    end

    // global advance: every stage moves unless the result register is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        seg_in.x0  = start_x;
        seg_in.y0  = start_y;
        seg_in.x1  = end_x;
        seg_in.y1  = end_y;
        seg_in.rej = 1'b0;
        seg_in.ovf = 1'b0;
    end

    // top cone line y = -t*x
    vcsc_line u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .top       (1'b1),
        .tan       (tan_reg),
        .in_valid  (in_valid),
        .in_seg    (seg_in),
        .out_valid (v_mid),
        .out_seg   (seg_mid)
    );

    // bottom cone line y = t*x; passes a rejected segment through untouched
    vcsc_line u_bot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .top       (1'b0),
        .tan       (tan_reg),
        .in_valid  (v_mid),
        .in_seg    (seg_mid),
        .out_valid (out_valid),
        .out_seg   (seg_out)
    );

    assign clip_start_x = seg_out.rej ? MINUS_ONE : seg_out.x0;
    assign clip_start_y = seg_out.rej ? MINUS_ONE : seg_out.y0;
    assign clip_end_x   = seg_out.rej ? MINUS_ONE : seg_out.x1;
    assign clip_end_y   = seg_out.rej ? MINUS_ONE : seg_out.y1;
    assign rejected     = seg_out.rej;
    assign overflow     = seg_out.ovf;

endmodule

// File: design/vcsc_line.sv
module vcsc_line (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               top,
    input  logic [vcsc_pkg::TAN_WIDTH-1:0]     tan,
    input  logic                               in_valid,
    input  vcsc_pkg::seg_t                     in_seg,
    output logic                               out_valid,
    output vcsc_pkg::seg_t                     out_seg
);

    localparam int CW   = vcsc_pkg::COORD_WIDTH;
    localparam int FRAC = vcsc_pkg::FRAC_BITS;
    localparam int TSW  = vcsc_pkg::TAN_WIDTH + 1;
    localparam int DXW  = CW + 1;
    localparam int PW   = 2 * CW;
    localparam int CRW  = 2 * CW + 1;
    localparam int TDXW = TSW + DXW;
    localparam int DENW = TDXW + 1;
    localparam int LW   = CW + TSW;
    localparam int CMPW = LW + 1;
    localparam int MLOW = CW + 2 + TSW;
    localparam int MHIW = CW + TSW;
    localparam int TCRW = CRW + TSW;
    localparam int NUMW = TCRW + 1;
    localparam int BW   = NUMW + 1;

    localparam logic [CW-1:0] LIM = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [DENW-1:0]   r_x;
        logic [CW-1:0]     q_x;
        logic [DENW-1:0]   r_y;
        logic [CW-1:0]     q_y;
        logic [DENW-1:0]   d;
        logic              neg_x;
        logic              neg_y;
        logic              big_x;
        logic              big_y;
        logic              skip;
        logic              act;
        logic              out0;
        logic              out1;
        vcsc_pkg::seg_t    seg;
    } div_t;

    // one restoring step on both quotients (shared divisor)
    function automatic div_t div_step(input div_t s);
        logic [DENW:0] rx2;
        logic [DENW:0] ry2;
        div_t          o;
        o   = s;
        rx2 = {s.r_x, s.q_x[CW-1]};
        ry2 = {s.r_y, s.q_y[CW-1]};
        if (rx2 >= {1'b0, s.d})
        begin
            o.r_x = DENW'(rx2 - {1'b0, s.d});
            o.q_x = {s.q_x[CW-2:0], 1'b1};
        end
        else
        begin
            o.r_x = DENW'(rx2);
            o.q_x = {s.q_x[CW-2:0], 1'b0};
        end
        if (ry2 >= {1'b0, s.d})
        begin
            o.r_y = DENW'(ry2 - {1'b0, s.d});
            o.q_y = {s.q_y[CW-2:0], 1'b1};
        end
        else
        begin
            o.r_y = DENW'(ry2);
            o.q_y = {s.q_y[CW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic signed [TSW-1:0] ts;
    assign ts = $signed({1'b0, tan});

    // ---------------- stage A: differences and products
    logic                   v_a_reg;
    vcsc_pkg::seg_t         seg_a_reg;
    logic signed [DXW-1:0]  dx_a_next, dy_a_next, dy_a_reg;
    logic signed [PW-1:0]   p1_a_next, p2_a_next, p1_a_reg, p2_a_reg;
    logic signed [TDXW-1:0] tdx_a_next, tdx_a_reg;
    logic signed [LW-1:0]   l0_a_next, l1_a_next, l0_a_reg, l1_a_reg;

    always_comb
    begin
        dx_a_next  = DXW'($signed(in_seg.x0)) - DXW'($signed(in_seg.x1));
        dy_a_next  = DXW'($signed(in_seg.y0)) - DXW'($signed(in_seg.y1));
        p1_a_next  = $signed(in_seg.x0) * $signed(in_seg.y1);
        p2_a_next  = $signed(in_seg.x1) * $signed(in_seg.y0);
        tdx_a_next = ts * dx_a_next;
        l0_a_next  = $signed(in_seg.x0) * ts;
        l1_a_next  = $signed(in_seg.x1) * ts;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_a_reg <= in_seg;
            dy_a_reg  <= dy_a_next;
            p1_a_reg  <= p1_a_next;
            p2_a_reg  <= p2_a_next;
            tdx_a_reg <= tdx_a_next;
            l0_a_reg  <= l0_a_next;
            l1_a_reg  <= l1_a_next;
        end
    end

    // ---------------- stage B: denominator, cross product, outside flags
    logic                    v_b_reg;
    vcsc_pkg::seg_t          seg_b_reg;
    logic signed [DENW-1:0]  den_b_next, den_b_reg;
    logic signed [CRW-1:0]   cr_b_next, cr_b_reg;
    logic signed [CMPW-1:0]  yf0, yf1, lc0, lc1;
    logic                    out0_b_next, out1_b_next, out0_b_reg, out1_b_reg;

    always_comb
    begin
        den_b_next = (DENW'(dy_a_reg) <<< FRAC)
                   + (top ? DENW'(tdx_a_reg) : -DENW'(tdx_a_reg));
        cr_b_next  = CRW'(p1_a_reg) - CRW'(p2_a_reg);
        yf0 = CMPW'($signed(seg_a_reg.y0)) <<< FRAC;
        yf1 = CMPW'($signed(seg_a_reg.y1)) <<< FRAC;
        lc0 = CMPW'(l0_a_reg);
        lc1 = CMPW'(l1_a_reg);
        out0_b_next = top ? (lc0 < -yf0) : (lc0 < yf0);
        out1_b_next = top ? (lc1 < -yf1) : (lc1 < yf1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b_reg <= 1'b0;
        end
        else if (en)
        begin
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_b_reg  <= seg_a_reg;
            den_b_reg  <= den_b_next;
            cr_b_reg   <= cr_b_next;
            out0_b_reg <= out0_b_next;
            out1_b_reg <= out1_b_next;
        end
    end

    // ---------------- stage C: t * cross product, split in two halves
    logic                   v_c_reg;
    vcsc_pkg::seg_t         seg_c_reg;
    logic signed [DENW-1:0] den_c_reg;
    logic signed [CRW-1:0]  cr_c_reg;
    logic signed [MLOW-1:0] mlo_c_next, mlo_c_reg;
    logic signed [MHIW-1:0] mhi_c_next, mhi_c_reg;
    logic                   out0_c_reg, out1_c_reg;

    always_comb
    begin
        mlo_c_next = $signed({1'b0, cr_b_reg[CW:0]}) * ts;
        mhi_c_next = $signed(cr_b_reg[CRW-1:CW+1]) * ts;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
        end
        else if (en)
        begin
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_c_reg  <= seg_b_reg;
            den_c_reg  <= den_b_reg;
            cr_c_reg   <= cr_b_reg;
            mlo_c_reg  <= mlo_c_next;
            mhi_c_reg  <= mhi_c_next;
            out0_c_reg <= out0_b_reg;
            out1_c_reg <= out1_b_reg;
        end
    end

    // ---------------- stage D: numerators
    logic                   v_d_reg;
    vcsc_pkg::seg_t         seg_d_reg;
    logic signed [DENW-1:0] den_d_reg;
    logic signed [TCRW-1:0] tcr;
    logic signed [NUMW-1:0] ixn_d_next, iyn_d_next, ixn_d_reg, iyn_d_reg;
    logic                   out0_d_reg, out1_d_reg;

    always_comb
    begin
        tcr = (TCRW'(mhi_c_reg) <<< (CW + 1)) + TCRW'(mlo_c_reg);
        iyn_d_next = top ? NUMW'(tcr) : -NUMW'(tcr);
        ixn_d_next = -(NUMW'(cr_c_reg) <<< FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
        end
        else if (en)
        begin
            v_d_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_d_reg  <= seg_c_reg;
            den_d_reg  <= den_c_reg;
            ixn_d_reg  <= ixn_d_next;
            iyn_d_reg  <= iyn_d_next;
            out0_d_reg <= out0_c_reg;
            out1_d_reg <= out1_c_reg;
        end
    end

    // ---------------- stage E: magnitudes and signs
    logic                  v_e_reg;
    vcsc_pkg::seg_t        seg_e_reg;
    logic [NUMW-1:0]       nx_e_next, ny_e_next, nx_e_reg, ny_e_reg;
    logic [DENW-1:0]       d_e_next, d_e_reg;
    logic                  negx_e_next, negy_e_next, skip_e_next;
    logic                  negx_e_reg, negy_e_reg, skip_e_reg;
    logic                  out0_e_reg, out1_e_reg;

    always_comb
    begin
        nx_e_next   = ixn_d_reg[NUMW-1] ? NUMW'(-ixn_d_reg) : NUMW'(ixn_d_reg);
        ny_e_next   = iyn_d_reg[NUMW-1] ? NUMW'(-iyn_d_reg) : NUMW'(iyn_d_reg);
        skip_e_next = (den_d_reg == '0);
        if (skip_e_next)
        begin
            d_e_next = DENW'(1);
        end
        else
        begin
            d_e_next = den_d_reg[DENW-1] ? DENW'(-den_d_reg) : DENW'(den_d_reg);
        end
        negx_e_next = ixn_d_reg[NUMW-1] ^ den_d_reg[DENW-1];
        negy_e_next = iyn_d_reg[NUMW-1] ^ den_d_reg[DENW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= 1'b0;
        end
        else if (en)
        begin
            v_e_reg <= v_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_e_reg  <= seg_d_reg;
            nx_e_reg   <= nx_e_next;
            ny_e_reg   <= ny_e_next;
            d_e_reg    <= d_e_next;
            negx_e_reg <= negx_e_next;
            negy_e_reg <= negy_e_next;
            skip_e_reg <= skip_e_next;
            out0_e_reg <= out0_d_reg;
            out1_e_reg <= out1_d_reg;
        end
    end

    // ---------------- stage F: range check, divider setup
    div_t            dv0_next;
    logic [BW-1:0]   dsh;

    always_comb
    begin
        dsh            = BW'(d_e_reg) << CW;
        dv0_next.d     = d_e_reg;
        dv0_next.big_x = (BW'(nx_e_reg) >= dsh);
        dv0_next.big_y = (BW'(ny_e_reg) >= dsh);
        dv0_next.r_x   = dv0_next.big_x ? '0 : DENW'(nx_e_reg >> CW);
        dv0_next.r_y   = dv0_next.big_y ? '0 : DENW'(ny_e_reg >> CW);
        dv0_next.q_x   = nx_e_reg[CW-1:0];
        dv0_next.q_y   = ny_e_reg[CW-1:0];
        dv0_next.neg_x = negx_e_reg;
        dv0_next.neg_y = negy_e_reg;
        dv0_next.skip  = skip_e_reg;
        dv0_next.act   = !seg_e_reg.rej;
        dv0_next.out0  = out0_e_reg;
        dv0_next.out1  = out1_e_reg;
        dv0_next.seg   = seg_e_reg;
    end

    // ---------------- divider: one quotient bit per stage
    div_t            dv_reg [CW+1];
    logic [CW:0]     dv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg <= '0;
        end
        else if (en)
        begin
            dv_v_reg <= {dv_v_reg[CW-1:0], v_e_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv0_next;
            for (int i = 0; i < CW; i++)
            begin
                dv_reg[i+1] <= div_step(dv_reg[i]);
            end
        end
    end

    // ---------------- stage G: saturate, clip decision
    div_t                  dl;
    logic                  ovfx, ovfy, eval;
    logic signed [CW-1:0]  ix, iy;
    vcsc_pkg::seg_t        seg_g_next, seg_g_reg;
    logic                  v_g_reg;

    always_comb
    begin
        dl   = dv_reg[CW];
        ovfx = dl.big_x || (dl.neg_x ? (dl.q_x > LIM) : (dl.q_x >= LIM));
        ovfy = dl.big_y || (dl.neg_y ? (dl.q_y > LIM) : (dl.q_y >= LIM));
        if (ovfx)
        begin
            ix = dl.neg_x ? $signed(LIM) : $signed(LIM - CW'(1));
        end
        else
        begin
            ix = dl.neg_x ? $signed(-dl.q_x) : $signed(dl.q_x);
        end
        if (ovfy)
        begin
            iy = dl.neg_y ? $signed(LIM) : $signed(LIM - CW'(1));
        end
        else
        begin
            iy = dl.neg_y ? $signed(-dl.q_y) : $signed(dl.q_y);
        end
        eval       = dl.act && !dl.skip;
        seg_g_next = dl.seg;
        if (eval)
        begin
            seg_g_next.ovf = dl.seg.ovf | ovfx | ovfy;
            if (ix > 0)
            begin
                if (dl.out0 && dl.out1)
                begin
                    seg_g_next.rej = 1'b1;
                end
                else
                begin
                    if (dl.out0)
                    begin
                        seg_g_next.x0 = ix;
                        seg_g_next.y0 = iy;
                    end
                    if (dl.out1)
                    begin
                        seg_g_next.x1 = ix;
                        seg_g_next.y1 = iy;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_g_reg <= 1'b0;
        end
        else if (en)
        begin
            v_g_reg <= dv_v_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_g_reg <= seg_g_next;
        end
    end

    assign out_valid = v_g_reg;
    assign out_seg   = seg_g_reg;

endmodule

// File: tb/clip_checker.sv
module clip_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [vcsc_pkg::TAN_WIDTH-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] start_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] start_y,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] end_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] end_y,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_start_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_start_y,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_end_x,
    input  logic signed [vcsc_pkg::COORD_WIDTH-1:0] clip_end_y,
    input  logic                                    rejected,
    input  logic                                    overflow,
    output int                                      err_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW   = vcsc_pkg::COORD_WIDTH;
    localparam int FRAC = vcsc_pkg::FRAC_BITS;

    typedef logic signed [127:0] wide_t;

    logic [vcsc_pkg::TAN_WIDTH-1:0] tangent;
    vcsc_pkg::seg_t                 clipped_q[$];

    // truncating quotient, saturated to the coordinate range
    function automatic logic signed [63:0] sat_quot(wide_t num, wide_t den, ref logic ovf);
        logic  neg;
        wide_t q;
        wide_t lim;
        neg = (num < 0) != (den < 0);
        q   = (num < 0 ? -num : num) / (den < 0 ? -den : den);
        lim = neg ? (wide_t'(1) <<< (CW - 1))
                  : (wide_t'(1) <<< (CW - 1)) - 1;
        if (q > lim)
        begin
            ovf = 1'b1;
            q   = lim;
        end
        return neg ? -q : q;
    endfunction

    // 1 when both ends are outside the cone line, met at x > 0
    function automatic logic clip_cone(ref wide_t px[2], ref wide_t py[2], input logic top,
                                       ref logic ovf);
        wide_t t;
        wide_t ts;
        wide_t den;
        wide_t cr;
        wide_t ix;
        wide_t iy;
        wide_t yf;
        logic  out_pt[2];
        t   = wide_t'(tangent);
        ts  = top ? t : -t;
        den = ((py[0] - py[1]) <<< FRAC) + ts * (px[0] - px[1]);
        if (den == 0)
            return 1'b0;
        cr = px[0] * py[1] - px[1] * py[0];
        ix = sat_quot(-(cr <<< FRAC), den, ovf);
        iy = sat_quot(ts * cr, den, ovf);
        if (ix <= 0)
            return 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            yf        = py[k] <<< FRAC;
            out_pt[k] = (px[k] * t) < (top ? -yf : yf);
        end
        if (out_pt[0] && out_pt[1])
            return 1'b1;
        for (int k = 0; k < 2; k++)
            if (out_pt[k])
            begin
                px[k] = ix;
                py[k] = iy;
            end
        return 1'b0;
    endfunction

    function automatic vcsc_pkg::seg_t clip_segment(logic signed [CW-1:0] sx, sy, ex, ey);
        wide_t          px[2];
        wide_t          py[2];
        logic           ovf;
        logic           rej;
        vcsc_pkg::seg_t s;
        px[0] = sx;
        py[0] = sy;
        px[1] = ex;
        py[1] = ey;
        ovf   = 1'b0;
        rej   = clip_cone(px, py, 1'b1, ovf);
        if (!rej)
            rej = clip_cone(px, py, 1'b0, ovf);
        if (rej)
        begin
            s.x0 = -(1 << FRAC);
            s.y0 = -(1 << FRAC);
            s.x1 = -(1 << FRAC);
            s.y1 = -(1 << FRAC);
        end
        else
        begin
            s.x0 = px[0][CW-1:0];
            s.y0 = py[0][CW-1:0];
            s.x1 = px[1][CW-1:0];
            s.y1 = py[1][CW-1:0];
        end
        s.rej = rej;
        s.ovf = ovf;
        return s;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    initial err_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        vcsc_pkg::seg_t e;
        if (!rst_n)
        begin
            tangent <= vcsc_pkg::TAN_RESET;
            clipped_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tangent <= cfg_data;
            if (in_valid && !in_stall)
                clipped_q.push_back(clip_segment(start_x, start_y, end_x, end_y));
            if (out_valid && !out_stall)
            begin
                if (clipped_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    err_count++;
                end
                else
                begin
                    e = clipped_q.pop_front();
                    check_field("clip_start_x", e.x0, clip_start_x);
                    check_field("clip_start_y", e.y0, clip_start_y);
                    check_field("clip_end_x", e.x1, clip_end_x);
                    check_field("clip_end_y", e.y1, clip_end_y);
                    check_field("rejected", e.rej, rejected);
                    check_field("overflow", e.ovf, overflow);
                end
            end
            pending = clipped_q.size();
        end
    end
endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = vcsc_pkg::COORD_WIDTH;
    localparam int TW        = vcsc_pkg::TAN_WIDTH;
    localparam int LATENCY   = 2 * (CW + 7);
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 730;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TW-1:0]        cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [CW-1:0] start_x = '0;
    logic signed [CW-1:0] start_y = '0;
    logic signed [CW-1:0] end_x = '0;
    logic signed [CW-1:0] end_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [CW-1:0] clip_start_x;
    logic signed [CW-1:0] clip_start_y;
    logic signed [CW-1:0] clip_end_x;
    logic signed [CW-1:0] clip_end_y;
    logic                 rejected;
    logic                 overflow;
    int                   err_count;
    int                   pending;
    int                   cycle = 0;
    bit                   calm = 1'b0;   // no idling at the tail

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    view_cone_segment_clipper_unit dut (.*);

    clip_checker chk (.*);

    // watchdog
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic write_tangent(logic [TW-1:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait out every result plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one request; idle bursts go in front of it unless calm
    task automatic send_segment(logic [31:0] sx, sy, ex, ey);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 32'(signed'($urandom_range(0, 40)) - 20) <<< 16;
            2:       return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            3:       return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
            default: return 32'(signed'($urandom_range(0, 600)) - 300) <<< 12;
        endcase
    endfunction

    // random tangent, mostly near realistic fields of view
    function automatic logic [TW-1:0] rand_tangent();
        case ($urandom_range(0, 3))
            0:       return TW'($urandom_range(1, 4194304));
            1:       return TW'(1);
            default: return TW'($urandom_range(20000, 200000));
        endcase
    endfunction

    initial
    begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7fff_ffff;
        localparam logic [31:0] MINV = 32'h8000_0000;
        logic [31:0] a;
        logic [31:0] b;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset tangent of 1.0
        send_segment(10 * ONE, -ONE, 10 * ONE, ONE);        // fully inside
        send_segment(ONE, 5 * ONE, 2 * ONE, 9 * ONE);       // both above bottom line
        send_segment(ONE, -5 * ONE, 2 * ONE, -9 * ONE);     // both below top line
        send_segment(4 * ONE, -8 * ONE, 4 * ONE, 0);        // start clipped at top
        send_segment(4 * ONE, 0, 4 * ONE, 8 * ONE);         // end clipped at bottom
        send_segment(4 * ONE, -8 * ONE, 4 * ONE, 8 * ONE);  // clipped on both lines
        send_segment(ONE, ONE, 2 * ONE, 2 * ONE);           // parallel to a cone line
        send_segment(-4 * ONE, -ONE, -2 * ONE, ONE);        // intersection behind viewer
        send_segment(0, 0, 0, 0);                           // degenerate point
        send_segment(MAXV, MINV, MAXV, MAXV);
        send_segment(MINV, MINV, MINV, MAXV);
        send_segment(MAXV, MAXV, MINV, MINV);
        send_segment(ONE, MAXV, 2, MINV);                   // quotient saturation
        send_segment(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
        drain();

        // tangent extremes
        write_tangent(TW'(1));
        send_segment(10 * ONE, ONE, 10 * ONE, -ONE);
        send_segment(ONE, MAXV, 3, MINV);
        send_segment(0, ONE, 0, -ONE);
        drain();
        write_tangent(23'd4194304);
        send_segment(ONE, 60 * ONE, ONE, -70 * ONE);
        send_segment(MAXV, MINV, 5, MAXV);
        drain();
        write_tangent(23'h7fffff);
        send_segment(2 * ONE, MAXV, 3 * ONE, MINV);
        drain();
        write_tangent(TW'(0));                              // collapsed cone
        send_segment(ONE, ONE, 2 * ONE, -ONE);
        send_segment(ONE, -ONE, 2 * ONE, -3 * ONE);
        drain();

        // random phases, each with its own tangent
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
            begin
                in_valid <= 1'b0;
                drain();
                write_tangent(rand_tangent());
            end
            if (i == N_RANDOM - 100)
                calm = 1'b1;
            a = rand_coord();
            b = rand_coord();
            if ($urandom_range(0, 3) != 0)
            begin
                // mostly in front of the viewer
                send_segment(a & 32'h3fff_ffff, b, rand_coord() & 32'h3fff_ffff,
                             rand_coord());
            end
            else
            begin
                send_segment(a, b, rand_coord(), rand_coord());
            end
        end
        in_valid <= 1'b0;
        drain();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
design/vcsc_pkg.sv
design/vcsc_line.sv
design/view_cone_segment_clipper_unit.sv
tb/clip_checker.sv
tb/testbench.sv
